/* rtl/core/macd_indicator_unit_defines.svh */
`ifndef MACD_INDICATOR_UNIT_DEFINES_SVH
`define MACD_INDICATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MACD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define MACD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/macd_pkg.sv */
package macd_pkg;

   // price and fixed-point format
   localparam int PRICE_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = PRICE_BITS + FRAC_BITS;
   localparam int MAG_W      = VAL_W + 1;

   // configuration fields
   localparam int PERIOD_W   = 8;
   localparam int ALPHA_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // seed sums hold up to 2^PERIOD_W values
   localparam int SUM_W      = VAL_W + PERIOD_W;

   // tick counter saturates at its all-ones value
   localparam int TICK_W     = 10;

   // multi-cycle scaler: chunk width and number of chunks
   localparam int MUL_W      = 32;
   localparam int MUL_STEPS  = (MAG_W + MUL_W - 1) / MUL_W;
   localparam int MUL_PAD_W  = MUL_STEPS * MUL_W;
   localparam int PROD_W     = MUL_PAD_W + ALPHA_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FAST_PERIOD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIGNAL_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_ALPHA    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_ALPHA    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SIGNAL_ALPHA  = 3'd5;

   // register reset values
   localparam logic [PERIOD_W-1:0] RST_FAST_PERIOD   = 8'd12;
   localparam logic [PERIOD_W-1:0] RST_SLOW_PERIOD   = 8'd26;
   localparam logic [PERIOD_W-1:0] RST_SIGNAL_PERIOD = 8'd9;
   localparam logic [ALPHA_W-1:0]  RST_FAST_ALPHA    = 16'd10082;
   localparam logic [ALPHA_W-1:0]  RST_SLOW_ALPHA    = 16'd4855;
   localparam logic [ALPHA_W-1:0]  RST_SIGNAL_ALPHA  = 16'd13107;

   // saturation limits of the macd value
   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // which average the datapath works on
   typedef logic [1:0] unit_type;
   localparam unit_type UNIT_FAST = 2'd0;
   localparam unit_type UNIT_SLOW = 2'd1;
   localparam unit_type UNIT_SIG  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic     load;
      unit_type unit;
      logic     ema_start;
      logic     ema_write;
      logic     seed_add;
      logic     div_start;
      logic     div_write;
      logic     macd_calc;
      logic     out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic unit_ok;
      logic macd_ok;
      logic seed_due;
      logic scale_done;
      logic div_done;
      logic rsp_free;
   } ctrl_status_type;

endpackage

/* rtl/core/macd_if.sv */
// price channel
interface macd_req_if import macd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] price;

   modport source (output valid, output price, input ready);
   modport sink   (input valid, input price, output ready);
endinterface

// result channel
interface macd_rsp_if import macd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] macd_value;
   logic signed [VAL_W-1:0] signal_value;
   logic                    macd_valid;
   logic                    signal_valid;
   logic                    cross_up;
   logic                    cross_down;
   logic                    falling_negative;

   modport source (output valid, output macd_value, output signal_value, output macd_valid,
                   output signal_valid, output cross_up, output cross_down,
                   output falling_negative, input ready);
   modport sink   (input valid, input macd_value, input signal_value, input macd_valid,
                   input signal_valid, input cross_up, input cross_down,
                   input falling_negative, output ready);
endinterface

// register write channel
interface macd_csr_if import macd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/macd_div.sv */
module macd_div import macd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output logic                done,
   output logic [SUM_W-1:0]    quotient
);

   localparam int DIV_CNT_W = $clog2(SUM_W);

   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [PERIOD_W-1:0]  dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [PERIOD_W:0]    trial;
   logic                 fits;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? PERIOD_W'(trial - {1'b0, dvs_ff}) : trial[PERIOD_W-1:0];
      quo_in = {quo_ff[SUM_W-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/macd_scale.sv */
module macd_scale import macd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MAG_W-1:0]   magnitude,
   input  logic [ALPHA_W-1:0] alpha,
   output logic               done,
   output logic [MAG_W-1:0]   scaled,
   output logic               inexact
);

   localparam int SCL_CNT_W = $clog2(MUL_STEPS + 1);

   logic [MUL_PAD_W-1:0]       mag_ff;
   logic [ALPHA_W-1:0]         alpha_ff;
   logic [MUL_W+ALPHA_W-1:0]   pp_ff;
   logic [PROD_W-1:0]          acc_ff;
   logic [SCL_CNT_W-1:0]       cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;

   // control: one partial product per cycle, accumulated in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + SCL_CNT_W'(1);
            if (cnt_ff == SCL_CNT_W'(MUL_STEPS)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // chunk multiply, most significant chunk first, and horner accumulate
   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff   <= MUL_PAD_W'(magnitude);
         alpha_ff <= alpha;
         acc_ff   <= '0;
      end else if (busy_ff) begin
         pp_ff  <= mag_ff[MUL_PAD_W-1 -: MUL_W] * alpha_ff;
         mag_ff <= mag_ff << MUL_W;
         if (cnt_ff != '0) begin
            acc_ff <= {acc_ff[PROD_W-MUL_W-1:0], {MUL_W{1'b0}}} + PROD_W'(pp_ff);
         end
      end
   end

   assign done    = done_ff;
   assign scaled  = acc_ff[ALPHA_W +: MAG_W];
   assign inexact = |acc_ff[ALPHA_W-1:0];

endmodule

/* rtl/core/macd_dp.sv */
module macd_dp import macd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output ctrl_status_type         status,
   input  logic [PRICE_BITS-1:0]   price,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_macd_value,
   output logic signed [VAL_W-1:0] rsp_signal_value,
   output logic                    rsp_macd_valid,
   output logic                    rsp_signal_valid,
   output logic                    rsp_cross_up,
   output logic                    rsp_cross_down,
   output logic                    rsp_falling_negative
);

   // configuration
   logic [PERIOD_W-1:0] fast_period_ff, slow_period_ff, signal_period_ff;
   logic [ALPHA_W-1:0]  fast_alpha_ff, slow_alpha_ff, signal_alpha_ff;

   // indicator state
   logic [VAL_W-1:0]        px_ff;
   logic [TICK_W-1:0]       tick_ff;
   logic [VAL_W-1:0]        fast_avg_ff, slow_avg_ff;
   logic signed [VAL_W-1:0] sig_avg_ff;
   logic [SUM_W-1:0]        fast_sum_ff, slow_sum_ff, sig_sum_ff;
   logic [PERIOD_W-1:0]     sig_cnt_ff;
   logic                    fast_ok_ff, slow_ok_ff, sig_ok_ff;
   logic signed [VAL_W-1:0] macd_ff;
   logic signed [VAL_W-1:0] prev_macd_ff, prev_sig_ff;
   logic                    prev_macd_ok_ff, prev_sig_ok_ff;
   logic                    down_ff;
   logic                    div_neg_ff;
   logic                    rsp_valid_ff;

   // result register
   logic signed [VAL_W-1:0] out_macd_ff, out_sig_ff;
   logic                    out_macd_ok_ff, out_sig_ok_ff;
   logic                    out_cu_ff, out_cd_ff, out_fn_ff;

   // unit selection
   logic [VAL_W-1:0]    sel_avg, sel_x;
   logic [ALPHA_W-1:0]  sel_alpha;
   logic                sel_ok, sel_signed;
   logic [SUM_W-1:0]    sel_sum;
   logic [PERIOD_W-1:0] sel_period, eff_period;
   logic [TICK_W-1:0]   sel_cnt;

   // arithmetic
   logic [MAG_W-1:0]        ext_x, ext_avg, mag_up, mag_dn, ema_mag;
   logic                    ema_down;
   logic [SUM_W-1:0]        val_ext, sum_new, div_mag;
   logic                    div_neg;
   logic [VAL_W-1:0]        ema_new, div_val, avg_new, q_ema, q_div;
   logic [MAG_W-1:0]        macd_diff;
   logic signed [VAL_W-1:0] macd_sat, sig_out;
   logic                    macd_ok, both_ok;

   // shared units
   logic                    scale_done, scale_inexact;
   logic [MAG_W-1:0]        scaled;
   logic                    div_done;
   logic [SUM_W-1:0]        quotient;

   macd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.ema_start),
      .magnitude (ema_mag),
      .alpha     (sel_alpha),
      .done      (scale_done),
      .scaled    (scaled),
      .inexact   (scale_inexact)
   );

   macd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_mag),
      .divisor  (sel_cnt[PERIOD_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   // operand mux for the average being worked on
   always_comb begin
      unique case (cmd.unit)
         UNIT_FAST: begin
            sel_avg    = fast_avg_ff;
            sel_x      = px_ff;
            sel_alpha  = fast_alpha_ff;
            sel_ok     = fast_ok_ff;
            sel_sum    = fast_sum_ff;
            sel_period = fast_period_ff;
            sel_cnt    = tick_ff;
            sel_signed = 1'b0;
         end
         UNIT_SLOW: begin
            sel_avg    = slow_avg_ff;
            sel_x      = px_ff;
            sel_alpha  = slow_alpha_ff;
            sel_ok     = slow_ok_ff;
            sel_sum    = slow_sum_ff;
            sel_period = slow_period_ff;
            sel_cnt    = tick_ff;
            sel_signed = 1'b0;
         end
         default: begin
            sel_avg    = sig_avg_ff;
            sel_x      = macd_ff;
            sel_alpha  = signal_alpha_ff;
            sel_ok     = sig_ok_ff;
            sel_sum    = sig_sum_ff;
            sel_period = signal_period_ff;
            sel_cnt    = TICK_W'(sig_cnt_ff);
            sel_signed = 1'b1;
         end
      endcase
   end

   // ema: direction and magnitude of the step
   always_comb begin
      ext_x    = {sel_signed & sel_x[VAL_W-1], sel_x};
      ext_avg  = {sel_signed & sel_avg[VAL_W-1], sel_avg};
      ema_down = $signed(ext_x) < $signed(ext_avg);
      mag_up   = ext_x - ext_avg;
      mag_dn   = ext_avg - ext_x;
      ema_mag  = ema_down ? mag_dn : mag_up;
   end

   // ema: floor step, going down subtracts the ceiling
   always_comb begin
      q_ema   = scaled[VAL_W-1:0];
      ema_new = sel_avg + (down_ff ? ~q_ema : q_ema) + VAL_W'(down_ff & ~scale_inexact);
   end

   // seed sum and effective period
   always_comb begin
      val_ext    = sel_signed ? {{(SUM_W-VAL_W){sel_x[VAL_W-1]}}, sel_x}
                              : {{(SUM_W-VAL_W){1'b0}}, sel_x};
      sum_new    = sel_sum + val_ext;
      eff_period = (sel_period == '0) ? PERIOD_W'(1) : sel_period;
   end

   // seed division on magnitudes, quotient truncates toward zero
   always_comb begin
      div_neg = sel_signed & sel_sum[SUM_W-1];
      div_mag = div_neg ? -sel_sum : sel_sum;
      q_div   = quotient[VAL_W-1:0];
      div_val = div_neg_ff ? -q_div : q_div;
      avg_new = cmd.div_write ? div_val : ema_new;
   end

   // macd: fast minus slow, saturated
   always_comb begin
      macd_ok   = fast_ok_ff & slow_ok_ff;
      macd_diff = {1'b0, fast_avg_ff} - {1'b0, slow_avg_ff};
      if (macd_diff[VAL_W] != macd_diff[VAL_W-1]) begin
         macd_sat = macd_diff[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         macd_sat = macd_diff[VAL_W-1:0];
      end
   end

   // result flags
   always_comb begin
      sig_out = sig_ok_ff ? sig_avg_ff : '0;
      both_ok = macd_ok & sig_ok_ff & prev_macd_ok_ff & prev_sig_ok_ff;
   end

   // status
   always_comb begin
      status.unit_ok    = sel_ok;
      status.macd_ok    = macd_ok;
      status.seed_due   = sel_cnt >= TICK_W'(eff_period);
      status.scale_done = scale_done;
      status.div_done   = div_done;
      status.rsp_free   = ~rsp_valid_ff | rsp_ready;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff   <= RST_FAST_PERIOD;
         slow_period_ff   <= RST_SLOW_PERIOD;
         signal_period_ff <= RST_SIGNAL_PERIOD;
         fast_alpha_ff    <= RST_FAST_ALPHA;
         slow_alpha_ff    <= RST_SLOW_ALPHA;
         signal_alpha_ff  <= RST_SIGNAL_ALPHA;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FAST_PERIOD:   fast_period_ff   <= csr_data[PERIOD_W-1:0];
            REG_SLOW_PERIOD:   slow_period_ff   <= csr_data[PERIOD_W-1:0];
            REG_SIGNAL_PERIOD: signal_period_ff <= csr_data[PERIOD_W-1:0];
            REG_FAST_ALPHA:    fast_alpha_ff    <= csr_data[ALPHA_W-1:0];
            REG_SLOW_ALPHA:    slow_alpha_ff    <= csr_data[ALPHA_W-1:0];
            REG_SIGNAL_ALPHA:  signal_alpha_ff  <= csr_data[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // indicator state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         fast_avg_ff     <= '0;
         slow_avg_ff     <= '0;
         sig_avg_ff      <= '0;
         fast_sum_ff     <= '0;
         slow_sum_ff     <= '0;
         sig_sum_ff      <= '0;
         sig_cnt_ff      <= '0;
         fast_ok_ff      <= 1'b0;
         slow_ok_ff      <= 1'b0;
         sig_ok_ff       <= 1'b0;
         prev_macd_ff    <= '0;
         prev_sig_ff     <= '0;
         prev_macd_ok_ff <= 1'b0;
         prev_sig_ok_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // saturating tick count
         if (cmd.load && (tick_ff != '1)) begin
            tick_ff <= tick_ff + TICK_W'(1);
         end
         // average update from ema step or seed
         if (cmd.ema_write || cmd.div_write) begin
            unique case (cmd.unit)
               UNIT_FAST: fast_avg_ff <= avg_new;
               UNIT_SLOW: slow_avg_ff <= avg_new;
               default:   sig_avg_ff  <= avg_new;
            endcase
         end
         if (cmd.div_write) begin
            unique case (cmd.unit)
               UNIT_FAST: fast_ok_ff <= 1'b1;
               UNIT_SLOW: slow_ok_ff <= 1'b1;
               default:   sig_ok_ff  <= 1'b1;
            endcase
         end
         // seed accumulation
         if (cmd.seed_add) begin
            unique case (cmd.unit)
               UNIT_FAST: fast_sum_ff <= sum_new;
               UNIT_SLOW: slow_sum_ff <= sum_new;
               default: begin
                  sig_sum_ff <= sum_new;
                  sig_cnt_ff <= sig_cnt_ff + PERIOD_W'(1);
               end
            endcase
         end
         // previous values for crossover detection
         if (cmd.out_load) begin
            prev_macd_ff    <= macd_ff;
            prev_sig_ff     <= sig_out;
            prev_macd_ok_ff <= macd_ok;
            prev_sig_ok_ff  <= sig_ok_ff;
         end
         // output register handshake
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= {price, {FRAC_BITS{1'b0}}};
      end
      if (cmd.ema_start) begin
         down_ff <= ema_down;
      end
      if (cmd.div_start) begin
         div_neg_ff <= div_neg;
      end
      if (cmd.macd_calc) begin
         macd_ff <= macd_ok ? macd_sat : '0;
      end
      if (cmd.out_load) begin
         out_macd_ff    <= macd_ff;
         out_sig_ff     <= sig_out;
         out_macd_ok_ff <= macd_ok;
         out_sig_ok_ff  <= sig_ok_ff;
         out_cu_ff      <= both_ok & (prev_macd_ff <= prev_sig_ff) & (macd_ff > sig_out);
         out_cd_ff      <= both_ok & (prev_macd_ff >= prev_sig_ff) & (macd_ff < sig_out);
         out_fn_ff      <= macd_ok & prev_macd_ok_ff & macd_ff[VAL_W-1]
                           & (macd_ff < prev_macd_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_macd_value       = out_macd_ff;
   assign rsp_signal_value     = out_sig_ff;
   assign rsp_macd_valid       = out_macd_ok_ff;
   assign rsp_signal_valid     = out_sig_ok_ff;
   assign rsp_cross_up         = out_cu_ff;
   assign rsp_cross_down       = out_cd_ff;
   assign rsp_falling_negative = out_fn_ff;

endmodule

/* rtl/core/macd_ctrl.sv */
module macd_ctrl import macd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UNIT = 3'd1;
   localparam logic [2:0] S_EMA  = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_MACD = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   unit_type   unit_ff, unit_in;
   logic [2:0] after_state;
   unit_type   after_unit;

   // where to go once the current average is done
   always_comb begin
      after_unit = unit_ff;
      unique case (unit_ff)
         UNIT_FAST: begin
            after_state = S_UNIT;
            after_unit  = UNIT_SLOW;
         end
         UNIT_SLOW: after_state = S_MACD;
         default:   after_state = S_OUT;
      endcase
   end

   // sequencer: fast, slow, macd, signal once macd is valid, result
   always_comb begin
      cmd       = '0;
      cmd.unit  = unit_ff;
      state_in  = state_ff;
      unit_in   = unit_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unit_in  = UNIT_FAST;
               state_in = S_UNIT;
            end
         end
         S_UNIT: begin
            if (status.unit_ok) begin
               cmd.ema_start = 1'b1;
               state_in      = S_EMA;
            end else begin
               cmd.seed_add = 1'b1;
               state_in     = S_CHK;
            end
         end
         S_EMA: begin
            if (status.scale_done) begin
               cmd.ema_write = 1'b1;
               state_in      = after_state;
               unit_in       = after_unit;
            end
         end
         S_CHK: begin
            if (status.seed_due) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = after_state;
               unit_in  = after_unit;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.div_write = 1'b1;
               state_in      = after_state;
               unit_in       = after_unit;
            end
         end
         S_MACD: begin
            cmd.macd_calc = 1'b1;
            if (status.macd_ok) begin
               unit_in  = UNIT_SIG;
               state_in = S_UNIT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         unit_ff  <= UNIT_FAST;
      end else begin
         state_ff <= state_in;
         unit_ff  <= unit_in;
      end
   end

endmodule

/* rtl/core/macd_indicator_unit.sv */
// MACD indicator: one price in, one result out per tick. Each price gets 16 fraction bits,
// feeds a fast and a slow exponential average (each seeded by the truncated mean of its
// first period prices), and their difference feeds a signal average seeded the same way.
// Results carry macd and signal in Q32.16, their valid flags, up/down crossovers and a
// falling-below-zero flag. Registers 0..5 are fast, slow and signal period, then fast,
// slow and signal alpha (Q0.16); write them only while no tick is in flight. A tick is
// worked on one at a time by a sequencer over a shared datapath: once all averages are
// seeded, each of the three averages takes a pass through the two-chunk 32x16 scaler,
// plus a step each for the macd and the result. The pass in which an average takes its
// seed is spent mostly in the one-bit-per-cycle seed divider instead. The result sits in
// an output register, so the next price is accepted while the previous result waits to
// be taken.
module macd_indicator_unit import macd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   macd_req_if.sink   req_if,
   macd_rsp_if.source rsp_if,
   macd_csr_if.sink   csr_if
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;

   // registers are always writable
   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;

   macd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   macd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .price                (req_if.price),
      .csr_write            (csr_if.valid),
      .csr_index            (csr_if.index),
      .csr_data             (csr_if.data),
      .rsp_ready            (rsp_if.ready),
      .rsp_valid            (rsp_if.valid),
      .rsp_macd_value       (rsp_if.macd_value),
      .rsp_signal_value     (rsp_if.signal_value),
      .rsp_macd_valid       (rsp_if.macd_valid),
      .rsp_signal_valid     (rsp_if.signal_valid),
      .rsp_cross_up         (rsp_if.cross_up),
      .rsp_cross_down       (rsp_if.cross_down),
      .rsp_falling_negative (rsp_if.falling_negative)
   );

endmodule

/* rtl/core/macd_checker.sv */
`include "macd_indicator_unit_defines.svh"

module macd_checker import macd_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [VAL_W-1:0] macd_value,
   input logic signed [VAL_W-1:0] signal_value,
   input logic                    macd_valid,
   input logic                    signal_valid,
   input logic                    cross_up,
   input logic                    cross_down,
   input logic                    falling_negative
);

   // a stalled result item keeps its values
   `MACD_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(macd_value) && $stable(signal_value), "stalled result changed")

   // the signal average is only seeded from valid macd values
   `MACD_ASSERT_IMP(a_sig_needs_macd, rsp_valid && signal_valid, macd_valid, "signal valid without macd valid")

   // nothing but zeros before both price averages are seeded
   `MACD_ASSERT_IMP(a_zero_until_valid, rsp_valid && !macd_valid, macd_value == '0 && signal_value == '0 && !cross_up && !cross_down && !falling_negative, "output before macd valid")

   // crossovers exclude each other and need both lines
   `MACD_ASSERT_IMP(a_cross_excl, rsp_valid && (cross_up || cross_down), !(cross_up && cross_down) && signal_valid, "bad crossover flags")

   // falling flag only for a negative macd
   `MACD_ASSERT_IMP(a_fall_neg, rsp_valid && falling_negative, macd_value[VAL_W-1] && macd_valid, "falling flag with non-negative macd")

endmodule

bind macd_indicator_unit macd_checker u_macd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .macd_value       (rsp_if.macd_value),
   .signal_value     (rsp_if.signal_value),
   .macd_valid       (rsp_if.macd_valid),
   .signal_valid     (rsp_if.signal_valid),
   .cross_up         (rsp_if.cross_up),
   .cross_down       (rsp_if.cross_down),
   .falling_negative (rsp_if.falling_negative)
);

/* verif/tb_macd_indicator_unit.sv */
`timescale 1ns / 1ps

module tb_macd_indicator_unit;
   import macd_pkg::*;

   // macd saturation limits, Q32.16 in 48 bits
   localparam longint MACD_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint MACD_LO = -MACD_HI - 1;

   // register indexes past the end of the map, written to check they are ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   localparam int CYCLE_LIMIT     = 5_000_000;
   localparam int RSP_HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES     = 300;
   localparam int RANDOM_PRICES   = 1500;
   localparam int TICK_MAX        = 1023;

   // expected outputs of one tick
   typedef struct {
      longint macd;
      longint sig;
      bit     macd_ok;
      bit     sig_ok;
      bit     up;
      bit     down;
      bit     falling;
   } tick_result_type;

   typedef struct {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_type;

   logic clock;
   logic reset;

   macd_req_if req_bus ();
   macd_rsp_if rsp_bus ();
   macd_csr_if csr_bus ();

   macd_indicator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // register shadow
   logic [PERIOD_W-1:0] fast_period, slow_period, signal_period;
   logic [ALPHA_W-1:0]  fast_alpha, slow_alpha, signal_alpha;

   // tracked indicator state
   int     tick_count, sig_count;
   longint fast_avg, slow_avg, sig_avg;
   longint fast_sum, slow_sum, sig_sum;
   longint prev_macd, prev_sig;
   bit     fast_seeded, slow_seeded, sig_seeded, prev_macd_ok, prev_sig_ok;

   tick_result_type pending_results[$];
   reg_write_type   reg_batch[$];

   int error_count   = 0;
   int checked_count = 0;
   int sent_count    = 0;
   int reg_writes    = 0;
   int up_count      = 0;
   int down_count    = 0;
   int falling_count = 0;
   int cycle_count   = 0;
   int stall_left    = 0;
   bit quiet;
   bit hold_request;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void clear_tracking();
      fast_period   = RST_FAST_PERIOD;
      slow_period   = RST_SLOW_PERIOD;
      signal_period = RST_SIGNAL_PERIOD;
      fast_alpha    = RST_FAST_ALPHA;
      slow_alpha    = RST_SLOW_ALPHA;
      signal_alpha  = RST_SIGNAL_ALPHA;
      tick_count    = 0;
      sig_count     = 0;
      fast_avg      = 0;
      slow_avg      = 0;
      sig_avg       = 0;
      fast_sum      = 0;
      slow_sum      = 0;
      sig_sum       = 0;
      prev_macd     = 0;
      prev_sig      = 0;
      fast_seeded   = 0;
      slow_seeded   = 0;
      sig_seeded    = 0;
      prev_macd_ok  = 0;
      prev_sig_ok   = 0;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_FAST_PERIOD:   fast_period   = data[PERIOD_W-1:0];
         REG_SLOW_PERIOD:   slow_period   = data[PERIOD_W-1:0];
         REG_SIGNAL_PERIOD: signal_period = data[PERIOD_W-1:0];
         REG_FAST_ALPHA:    fast_alpha    = data[ALPHA_W-1:0];
         REG_SLOW_ALPHA:    slow_alpha    = data[ALPHA_W-1:0];
         REG_SIGNAL_ALPHA:  signal_alpha  = data[ALPHA_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic int seed_count(logic [PERIOD_W-1:0] period);
      return (period == 0) ? 1 : int'(period);
   endfunction

   // avg + floor((x - avg) * alpha / 2^16), exact in both directions
   function automatic longint ema_step(longint avg, longint x, logic [ALPHA_W-1:0] alpha);
      longint unsigned diff, lo, s;
      diff = (x >= avg) ? x - avg : avg - x;
      lo   = (diff & 64'hFFFF) * alpha;
      s    = (diff >> 16) * alpha + (lo >> 16);
      if (x >= avg) return avg + longint'(s);
      // rounding toward minus infinity on the way down
      if (lo[15:0] != 0) s++;
      return avg - longint'(s);
   endfunction

   // one price average: sum until seeded, then follow the price
   function automatic void track_price_average(inout longint avg, inout longint sum,
                                               inout bit seeded, input longint px,
                                               input logic [PERIOD_W-1:0] period,
                                               input logic [ALPHA_W-1:0] alpha);
      if (seeded) begin
         avg = ema_step(avg, px, alpha);
      end else begin
         sum += px;
         if (tick_count >= seed_count(period)) begin
            avg    = sum / tick_count;
            seeded = 1'b1;
         end
      end
   endfunction

   function automatic tick_result_type advance_price(logic [PRICE_BITS-1:0] price);
      longint          px, d;
      tick_result_type r;
      r  = '{default: 0};
      px = longint'({16'b0, price, 16'b0});
      if (tick_count < TICK_MAX) tick_count++;
      track_price_average(fast_avg, fast_sum, fast_seeded, px, fast_period, fast_alpha);
      track_price_average(slow_avg, slow_sum, slow_seeded, px, slow_period, slow_alpha);
      r.macd_ok = fast_seeded && slow_seeded;
      if (r.macd_ok) begin
         d      = fast_avg - slow_avg;
         r.macd = (d > MACD_HI) ? MACD_HI : ((d < MACD_LO) ? MACD_LO : d);
         // signal seed counts real macd values only
         if (sig_seeded) begin
            sig_avg = ema_step(sig_avg, r.macd, signal_alpha);
         end else begin
            sig_sum += r.macd;
            sig_count++;
            if (sig_count >= seed_count(signal_period)) begin
               sig_avg    = sig_sum / sig_count;
               sig_seeded = 1'b1;
            end
         end
      end
      r.sig_ok = sig_seeded;
      if (sig_seeded) r.sig = sig_avg;
      if (r.macd_ok && r.sig_ok && prev_macd_ok && prev_sig_ok) begin
         r.up   = (prev_macd <= prev_sig) && (r.macd > r.sig);
         r.down = (prev_macd >= prev_sig) && (r.macd < r.sig);
      end
      if (r.macd_ok && prev_macd_ok) r.falling = (r.macd < 0) && (r.macd < prev_macd);
      prev_macd    = r.macd;
      prev_sig     = r.sig;
      prev_macd_ok = r.macd_ok;
      prev_sig_ok  = r.sig_ok;
      return r;
   endfunction

   // ---------------------------------------------------------------- helpers

   // mostly short gaps, sometimes long, none in quiet stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_period();
      logic [PERIOD_W-1:0] p;
      case ($urandom_range(0, 3))
         0:       p = 8'd2;
         1:       p = 8'd255;
         default: p = 8'($urandom);
      endcase
      // upper data bits are don't-care for a period register
      return {8'($urandom), p};
   endfunction

   function automatic logic [ALPHA_W-1:0] pick_alpha();
      int unsigned span;
      span = $urandom_range(2, 60);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'd1;
         2:       return '1;
         3, 4:    return 16'($urandom);
         default: return 16'(32'd131072 / (span + 1));
      endcase
   endfunction

   function automatic void set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      reg_write_type w;
      w.index = index;
      w.data  = data;
      reg_batch.insert(reg_batch.size(), w);
   endfunction

   // stop offering prices and wait for every pending result
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // write the queued registers once the block is idle
   task automatic commit_regs();
      reg_write_type w;
      wait_drained();
      while (reg_batch.size() != 0) begin
         w = reg_batch.pop_front();
         csr_bus.valid <= 1'b1;
         csr_bus.index <= w.index;
         csr_bus.data  <= w.data;
         do @(posedge clock); while (!csr_bus.ready);
         apply_reg(w.index, w.data);
         reg_writes++;
      end
      csr_bus.valid <= 1'b0;
   endtask

   // offer one price item after a random gap, valid stays up for back-to-back items
   task automatic send_price(input logic [PRICE_BITS-1:0] price);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.price <= price;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.insert(pending_results.size(), advance_price(price));
      sent_count++;
   endtask

   // ---------------------------------------------------------------- tests

   // seeding with fast period above slow, a zero period and periods lowered mid-seed
   task automatic test_seeding();
      set_reg(REG_SPARE_A, 16'h0001);
      set_reg(REG_SPARE_B, 16'hFFFF);
      set_reg(REG_FAST_PERIOD, {8'hA5, 8'd255});
      set_reg(REG_SLOW_PERIOD, {8'h5A, 8'd3});
      set_reg(REG_SIGNAL_PERIOD, {8'hFF, 8'd255});
      set_reg(REG_FAST_ALPHA, RST_FAST_ALPHA);
      set_reg(REG_SLOW_ALPHA, RST_SLOW_ALPHA);
      set_reg(REG_SIGNAL_ALPHA, RST_SIGNAL_ALPHA);
      commit_regs();
      send_price(32'h0000_0000);
      send_price(32'hFFFF_FFFF);
      send_price(32'h0000_0001);
      send_price(32'h8000_0000);
      // zero period acts as one, fast seeds on the next tick over all five prices
      set_reg(REG_FAST_PERIOD, 16'hC300);
      commit_regs();
      send_price(32'h7FFF_FFFF);
      send_price(32'h5555_5555);
      send_price(32'hAAAA_AAAA);
      // signal period dropped below the count already summed
      set_reg(REG_SIGNAL_PERIOD, {8'h3C, 8'd2});
      commit_regs();
      send_price(32'h0000_FFFF);
      send_price(32'hFFFF_0000);
      send_price(32'h1234_5678);
   endtask

   // macd clamps at both ends, zero alpha holds an average
   task automatic test_saturation();
      set_reg(REG_FAST_ALPHA, 16'hFFFF);
      set_reg(REG_SLOW_ALPHA, 16'h0000);
      set_reg(REG_SIGNAL_ALPHA, 16'hFFFF);
      commit_regs();
      send_price(32'hFFFF_FFFF);
      send_price(32'hFFFF_FFFF);
      send_price(32'h0000_0000);
      set_reg(REG_SLOW_ALPHA, 16'hFFFF);
      commit_regs();
      send_price(32'hFFFF_FFFF);
      set_reg(REG_SLOW_ALPHA, 16'h0000);
      set_reg(REG_SIGNAL_ALPHA, 16'h0000);
      commit_regs();
      send_price(32'h0000_0000);
      send_price(32'h0000_0000);
   endtask

   // result side holds off long enough that the input backs up
   task automatic test_output_stall();
      set_reg(REG_FAST_ALPHA, RST_FAST_ALPHA);
      set_reg(REG_SLOW_ALPHA, RST_SLOW_ALPHA);
      set_reg(REG_SIGNAL_ALPHA, RST_SIGNAL_ALPHA);
      commit_regs();
      quiet        = 1'b1;
      hold_request = 1'b1;
      repeat (12) send_price($urandom);
      quiet = 1'b0;
   endtask

   // trending random walks with noise, new register settings per segment
   task automatic test_random();
      int     seg_len, phase_left, r, done;
      longint level, scale, drift;
      done       = 0;
      phase_left = 0;
      drift      = 0;
      while (done < RANDOM_PRICES) begin
         set_reg(REG_FAST_PERIOD, pick_period());
         set_reg(REG_SLOW_PERIOD, pick_period());
         set_reg(REG_SIGNAL_PERIOD, pick_period());
         set_reg(REG_FAST_ALPHA, pick_alpha());
         set_reg(REG_SLOW_ALPHA, pick_alpha());
         set_reg(REG_SIGNAL_ALPHA, pick_alpha());
         commit_regs();
         quiet   = ($urandom_range(0, 3) == 0);
         seg_len = $urandom_range(60, 200);
         case ($urandom_range(0, 4))
            0:       scale = 1;
            1:       scale = 100;
            2:       scale = 10000;
            3:       scale = 1 << 20;
            default: scale = 1 << 28;
         endcase
         level = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 1000))
                                             : longint'($urandom);
         repeat (seg_len) begin
            // drift takes a new random direction every 5 to 40 prices to force crossings
            if (phase_left == 0) begin
               phase_left = $urandom_range(5, 40);
               drift      = $urandom_range(0, 1) ? scale / 4 : -(scale / 4);
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 4) begin
               level = longint'($urandom);
            end else if (r < 6) begin
               level = (r == 4) ? 0 : longint'(32'hFFFF_FFFF);
            end else begin
               level += drift + longint'($urandom_range(0, int'(2 * scale))) - scale;
            end
            if (level < 0) level = 0;
            if (level > longint'(32'hFFFF_FFFF)) level = longint'(32'hFFFF_FFFF);
            send_price(level[31:0]);
         end
         done += seg_len;
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------- result side

   // receiver stalls, plus one long hold when asked
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         stall_left   = RSP_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         error_count++;
      end
   endfunction

   // compare each result item with the oldest expectation
   always @(posedge clock) begin : result_check
      tick_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with no price pending");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("macd_value", want.macd, 64'(rsp_bus.macd_value));
            check_field("signal_value", want.sig, 64'(rsp_bus.signal_value));
            check_field("macd_valid", 64'(want.macd_ok), 64'(rsp_bus.macd_valid));
            check_field("signal_valid", 64'(want.sig_ok), 64'(rsp_bus.signal_valid));
            check_field("cross_up", 64'(want.up), 64'(rsp_bus.cross_up));
            check_field("cross_down", 64'(want.down), 64'(rsp_bus.cross_down));
            check_field("falling_negative", 64'(want.falling),
                        64'(rsp_bus.falling_negative));
            checked_count++;
            up_count      += want.up;
            down_count    += want.down;
            falling_count += want.falling;
         end
      end
   end

   // run length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_results.size());
         $display("macd_indicator_unit regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.price = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      quiet         = 1'b0;
      hold_request  = 1'b0;
      clear_tracking();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_seeding();
      test_saturation();
      test_output_stall();
      test_random();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d prices sent, %0d results checked, %0d register writes",
               sent_count, checked_count, reg_writes);
      $display("%0d up crossings, %0d down crossings, %0d falling-below-zero ticks seen",
               up_count, down_count, falling_count);
      if (error_count == 0) begin
         $display("macd_indicator_unit regression: pass");
      end else begin
         $display("macd_indicator_unit regression: fail");
      end
      $finish;
   end

endmodule

/* macd_indicator_unit.f */
+incdir+rtl/core
rtl/core/macd_pkg.sv
rtl/core/macd_if.sv
rtl/core/macd_div.sv
rtl/core/macd_scale.sv
rtl/core/macd_dp.sv
rtl/core/macd_ctrl.sv
rtl/core/macd_indicator_unit.sv
rtl/core/macd_checker.sv
verif/tb_macd_indicator_unit.sv
